/* design/rcmc_pkg.sv */
// Package with shared constants and types for the random contraction min-cut block.
package rcmc_pkg;

    localparam int MAX_VERTICES_DEF = 256;
    localparam int MAX_EDGES_DEF    = 1024;
    localparam int MAX_TRIES_DEF    = 65536;

    localparam int VTX_W   = 8;
    localparam int CUT_W   = 11;
    localparam int STAT_W  = 2;
    localparam int VCNT_W  = 9;
    localparam int SEED_W  = 32;
    localparam int CFG_W   = 32;

    localparam logic [31:0] LFSR_TAPS = 32'h8020_0003;

    // Register indexes of the configuration port.
    localparam logic CFG_VERTEX_COUNT = 1'b0;
    localparam logic CFG_RANDOM_SEED  = 1'b1;

    // Result status codes.
    localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_W-1:0] ST_NO_EDGES = 2'd1;
    localparam logic [STAT_W-1:0] ST_GAVE_UP  = 2'd2;

    typedef enum logic [3:0] {
        S_LOAD,
        S_CLEAR,
        S_PICK,
        S_EDGE,
        S_FIND_A,
        S_FIND_B,
        S_MERGE,
        S_CNT_RD,
        S_CNT_EDGE,
        S_CNT_A,
        S_CNT_B,
        S_DONE
    } rcmc_state_t;

endpackage

/* design/rcmc_if.sv */
// Valid/ready channel interfaces for edge words and result words.
interface rcmc_edge_if;
    logic       valid;
    logic       ready;
    logic [7:0] src_vertex;
    logic [7:0] dst_vertex;
    logic       last;
    modport source (output valid, src_vertex, dst_vertex, last, input ready);
    modport sink   (input valid, src_vertex, dst_vertex, last, output ready);
endinterface

interface rcmc_result_if;
    logic        valid;
    logic        ready;
    logic [10:0] cut_edges;
    logic [1:0]  status;
    modport source (output valid, cut_edges, status, input ready);
    modport sink   (input valid, cut_edges, status, output ready);
endinterface

/* design/random_contraction_min_cut.sv */
// Top level of the random contraction (Karger) min-cut trial engine.
// Edges load at one word per cycle, unless a result waits, into an edge memory
// in the load state. The word marked last starts one trial: a clear pass over the
// parent valid bits, then a series of picks, each of which runs a modulo unit
// that reduces the LFSR value by the edge count; a pick whose edge has an
// out-of-range endpoint ends without a merge. Every union-find step is one read
// of the single-port parent memory. The count pass then walks the roots of each
// stored in-range edge and skips each out-of-range edge. No new edge word is
// taken until the result word has been handed off.
module random_contraction_min_cut
    import rcmc_pkg::*;
#(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF,
    parameter int MAX_EDGES    = MAX_EDGES_DEF,
    parameter int MAX_TRIES    = MAX_TRIES_DEF
)(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  logic                    cfg_index,
    input  logic [rcmc_pkg::CFG_W-1:0] cfg_data,
    rcmc_edge_if.sink               edge_in,
    rcmc_result_if.source           result
);
    import rcmc_pkg::*;

    localparam int VA_W  = $clog2(MAX_VERTICES);
    localparam int VN_W  = $clog2(MAX_VERTICES + 1);
    localparam int EA_W  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int EN_W  = $clog2(MAX_EDGES + 1);
    localparam int TR_W  = $clog2(MAX_TRIES + 1);
    localparam int PW    = VN_W;   // parent entry width

    // Configuration registers and LFSR.
    logic [VCNT_W-1:0] vcount_reg;
    logic [31:0]       lfsr_reg, lfsr_next;

    // Memories.
    logic [15:0]   edge_mem [MAX_EDGES];
    logic [PW-1:0] par_mem  [MAX_VERTICES];
    logic [MAX_VERTICES-1:0] pvalid_reg;
    logic [15:0]   edge_rd;
    logic [PW-1:0] par_rd;

    rcmc_state_t state_reg, state_next;
    logic [EN_W-1:0] nedge_reg;
    logic [VN_W-1:0] nv_reg, sets_reg;
    logic [TR_W-1:0] tries_reg;
    logic [EN_W-1:0] cidx_reg;
    logic [CUT_W-1:0] cut_reg;
    logic [VN_W-1:0] b_reg, ra_reg;
    logic [VN_W-1:0] walk_reg;
    logic [VN_W-1:0] steps_reg;
    logic            rd_pend_reg;
    logic            res_valid_reg;
    logic [CUT_W-1:0] res_cut_reg;
    logic [STAT_W-1:0] res_stat_reg;

    // Modulo unit: restoring remainder of lfsr by edge count, one bit a cycle.
    logic [EN_W:0]   rem_reg;
    logic [31:0]     dvd_reg;
    logic [5:0]      mcnt_reg;
    logic            mbusy_reg;
    logic [EN_W:0]   rem_sh;
    assign rem_sh = {rem_reg[EN_W-1:0], dvd_reg[31]};

    // Effective vertex count with clamping.
    logic [VN_W-1:0] nv_eff;
    always_comb
    begin
        if (vcount_reg < VCNT_W'(2))
            nv_eff = VN_W'(2);
        else if (32'(vcount_reg) > 32'(MAX_VERTICES))
            nv_eff = VN_W'(MAX_VERTICES);
        else
            nv_eff = VN_W'(vcount_reg);
    end

    logic in_acc;
    assign edge_in.ready = (state_reg == S_LOAD) && !res_valid_reg;
    assign in_acc        = edge_in.valid && edge_in.ready;

    assign result.valid     = res_valid_reg;
    assign result.cut_edges = res_cut_reg;
    assign result.status    = res_stat_reg;

    // Walk state: an in-range vertex has a parent while its valid bit is set.
    logic walk_has_par;
    assign walk_has_par = (walk_reg < VN_W'(MAX_VERTICES)) && pvalid_reg[walk_reg[VA_W-1:0]]
                          && (steps_reg < VN_W'(MAX_VERTICES));

    logic [VA_W-1:0] par_addr;
    logic            par_we;
    assign par_addr = (state_reg == S_MERGE) ? ra_reg[VA_W-1:0] : walk_reg[VA_W-1:0];
    assign par_we   = (state_reg == S_MERGE) && (ra_reg != walk_reg)
                      && (ra_reg < VN_W'(MAX_VERTICES));

    logic ea_oob, eb_oob;
    assign ea_oob = VN_W'(edge_rd[7:0])  >= nv_reg;
    assign eb_oob = VN_W'(edge_rd[15:8]) >= nv_reg;

    logic [EA_W-1:0] edge_raddr;
    assign edge_raddr = (state_reg == S_EDGE) ? rem_reg[EA_W-1:0] : cidx_reg[EA_W-1:0];

    // Edge memory: write on load, registered read.
    always_ff @(posedge clk)
    begin
        if (in_acc && (nedge_reg < EN_W'(MAX_EDGES)))
            edge_mem[nedge_reg[EA_W-1:0]] <= {edge_in.dst_vertex, edge_in.src_vertex};
        edge_rd <= edge_mem[edge_raddr];
    end

    // Parent memory: single port, registered read.
    always_ff @(posedge clk)
    begin
        if (par_we)
            par_mem[par_addr] <= walk_reg;
        par_rd <= par_mem[par_addr];
    end

    // LFSR step value.
    always_comb
    begin
        lfsr_next = lfsr_reg >> 1;
        if (lfsr_reg[0])
            lfsr_next = lfsr_next ^ LFSR_TAPS;
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_LOAD:     if (in_acc && edge_in.last) state_next = S_CLEAR;
            S_CLEAR:    state_next = (nedge_reg == '0) ? S_DONE : S_PICK;
            S_PICK:
            begin
                if (sets_reg <= VN_W'(2))
                    state_next = S_CNT_RD;
                else if (32'(tries_reg) >= 32'(MAX_TRIES))
                    state_next = S_DONE;
                else
                    state_next = S_EDGE;
            end
            S_EDGE:
            begin
                if (!mbusy_reg && rd_pend_reg)
                    state_next = (ea_oob || eb_oob) ? S_PICK : S_FIND_A;
            end
            S_FIND_A:   if (!rd_pend_reg && !walk_has_par) state_next = S_FIND_B;
            S_FIND_B:   if (!rd_pend_reg && !walk_has_par) state_next = S_MERGE;
            S_MERGE:    state_next = S_PICK;
            S_CNT_RD:   state_next = (cidx_reg == nedge_reg) ? S_DONE : S_CNT_EDGE;
            S_CNT_EDGE: state_next = (ea_oob || eb_oob) ? S_CNT_RD : S_CNT_A;
            S_CNT_A:    if (!rd_pend_reg && !walk_has_par) state_next = S_CNT_B;
            S_CNT_B:    if (!rd_pend_reg && !walk_has_par) state_next = S_CNT_RD;
            S_DONE:     if (!res_valid_reg) state_next = S_LOAD;
            default:    state_next = S_LOAD;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_LOAD;
        else
            state_reg <= state_next;
    end

    // Datapath registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vcount_reg    <= VCNT_W'(4);
            lfsr_reg      <= 32'd1;
            nedge_reg     <= '0;
            pvalid_reg    <= '0;
            res_valid_reg <= 1'b0;
            mbusy_reg     <= 1'b0;
            rd_pend_reg   <= 1'b0;
            sets_reg      <= '0;
            tries_reg     <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_VERTEX_COUNT)
                    vcount_reg <= cfg_data[VCNT_W-1:0];
                else
                    lfsr_reg <= (cfg_data == '0) ? 32'd1 : cfg_data;
            end
            if (res_valid_reg && result.ready)
                res_valid_reg <= 1'b0;

            unique case (state_reg)
                S_LOAD:
                begin
                    if (in_acc && (nedge_reg < EN_W'(MAX_EDGES)))
                        nedge_reg <= nedge_reg + 1'b1;
                end
                S_CLEAR:
                begin
                    pvalid_reg <= '0;
                    nv_reg     <= nv_eff;
                    sets_reg   <= nv_eff;
                    tries_reg  <= '0;
                    cidx_reg   <= '0;
                    cut_reg    <= '0;
                end
                S_PICK:
                begin
                    if (sets_reg > VN_W'(2) && 32'(tries_reg) < 32'(MAX_TRIES))
                    begin
                        tries_reg   <= tries_reg + 1'b1;
                        lfsr_reg    <= lfsr_next;
                        dvd_reg     <= lfsr_next;
                        rem_reg     <= '0;
                        mcnt_reg    <= '0;
                        mbusy_reg   <= 1'b1;
                        rd_pend_reg <= 1'b0;
                    end
                end
                S_EDGE:
                begin
                    if (mbusy_reg)
                    begin
                        dvd_reg <= dvd_reg << 1;
                        if (rem_sh >= {1'b0, nedge_reg})
                            rem_reg <= rem_sh - {1'b0, nedge_reg};
                        else
                            rem_reg <= rem_sh;
                        mcnt_reg <= mcnt_reg + 1'b1;
                        if (mcnt_reg == 6'd31)
                            mbusy_reg <= 1'b0;
                    end
                    else if (!rd_pend_reg)
                        rd_pend_reg <= 1'b1;
                    else
                    begin
                        b_reg       <= VN_W'(edge_rd[15:8]);
                        walk_reg    <= VN_W'(edge_rd[7:0]);
                        steps_reg   <= '0;
                        rd_pend_reg <= 1'b1;
                    end
                end
                S_CNT_EDGE:
                begin
                    // An edge with an endpoint out of range is skipped.
                    if (ea_oob || eb_oob)
                        cidx_reg <= cidx_reg + 1'b1;
                    b_reg       <= VN_W'(edge_rd[15:8]);
                    walk_reg    <= VN_W'(edge_rd[7:0]);
                    steps_reg   <= '0;
                    rd_pend_reg <= 1'b1;
                end
                S_FIND_A, S_FIND_B, S_CNT_A, S_CNT_B:
                begin
                    // Each walk step reads the parent entry, then follows it.
                    if (rd_pend_reg)
                        rd_pend_reg <= 1'b0;
                    else if (walk_has_par)
                    begin
                        walk_reg    <= par_rd;
                        steps_reg   <= steps_reg + 1'b1;
                        rd_pend_reg <= 1'b1;
                    end
                    else if (state_reg == S_FIND_A || state_reg == S_CNT_A)
                    begin
                        ra_reg      <= walk_reg;
                        walk_reg    <= b_reg;
                        steps_reg   <= '0;
                        rd_pend_reg <= 1'b1;
                    end
                    else if (state_reg == S_CNT_B)
                    begin
                        if (ra_reg != walk_reg)
                            cut_reg <= cut_reg + 1'b1;
                        cidx_reg <= cidx_reg + 1'b1;
                    end
                end
                S_MERGE:
                begin
                    if (par_we)
                    begin
                        pvalid_reg[ra_reg[VA_W-1:0]] <= 1'b1;
                        sets_reg <= sets_reg - 1'b1;
                    end
                end
                S_DONE:
                begin
                    if (!res_valid_reg)
                    begin
                        res_valid_reg <= 1'b1;
                        nedge_reg     <= '0;
                        if (nedge_reg == '0)
                        begin
                            res_stat_reg <= ST_NO_EDGES;
                            res_cut_reg  <= '0;
                        end
                        else if (sets_reg > VN_W'(2))
                        begin
                            res_stat_reg <= ST_GAVE_UP;
                            res_cut_reg  <= '0;
                        end
                        else
                        begin
                            res_stat_reg <= ST_OK;
                            res_cut_reg  <= cut_reg;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

endmodule

/* design/rcmc_checker.sv */
// Port-level assertions for the min-cut block, bound to the top level.
module rcmc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        in_last,
    input logic        out_valid,
    input logic        out_ready,
    input logic [10:0] cut_edges,
    input logic [1:0]  status
);
    import rcmc_pkg::*;

    // A result is only ever ok, empty or gave up.
    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == ST_OK || status == ST_NO_EDGES || status == ST_GAVE_UP))
        else $error("bad status code");

    // Error results carry no cut count.
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != ST_OK) |-> cut_edges == '0)
        else $error("error result with nonzero cut");

    // After a last word is taken, no word is taken in the next cycle.
    a_last_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && in_last) |=> !in_ready)
        else $error("input taken during trial");

    // A waiting result holds its value.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(cut_edges) && $stable(status)))
        else $error("result changed while stalled");
endmodule

bind random_contraction_min_cut rcmc_checker u_rcmc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (edge_in.valid),
    .in_ready  (edge_in.ready),
    .in_last   (edge_in.last),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .cut_edges (result.cut_edges),
    .status    (result.status)
);
